// ----- sv/xmt_pkg.sv -----
`default_nettype none
package xmt_pkg;

  // default replay depth for the start tag name
  localparam int NAME_DEPTH_DEF = 32;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // segment kinds
  localparam logic [2:0] KIND_TEXT    = 3'd0;
  localparam logic [2:0] KIND_DECL    = 3'd1;
  localparam logic [2:0] KIND_STAG    = 3'd2;
  localparam logic [2:0] KIND_ETAG    = 3'd3;
  localparam logic [2:0] KIND_COMMENT = 3'd4;
  localparam logic [2:0] KIND_DOCTYPE = 3'd5;

  // characters of interest
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;

  // lexer modes
  typedef enum logic [7:0] {
    MODE_TEXT    = 8'b0000_0001,
    MODE_BRACKET = 8'b0000_0010,
    MODE_DECL    = 8'b0000_0100,
    MODE_STAG    = 8'b0000_1000,
    MODE_ETAG    = 8'b0001_0000,
    MODE_SIGN    = 8'b0010_0000,
    MODE_COMMENT = 8'b0100_0000,
    MODE_DOCTYPE = 8'b1000_0000
  } mode_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_CMD   = 3'b001,
    BK_FETCH = 3'b010,
    BK_SEND  = 3'b100
  } bk_state_t;

  // one command from front to back: a result plus tag name operations
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       has;
    logic       seg_end;
    logic       nonspace;
    logic       err;
    logic       name_clear;
    logic       name_feed;
    logic       replay;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || is_upper(c) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h3A || c == 8'h2D ||
           c == 8'h2E || c == 8'h5F;
  endfunction

endpackage
`default_nettype wire

// ----- sv/xml_markup_tokenizer_top.sv -----
// XML byte lexer: labels each document byte with its segment kind.
// Input channel: in_valid / in_stall / in_byte, one document byte per item.
// Output channel: out_valid / out_stall and the result fields; each input
// byte gives zero or more result items, the final one flagged by last.
// Bytes that give no result (before the first '<', the markup openers, held
// comment bytes) are consumed without any output item.
// Each result is written into the command queue and then into the output
// register before it leaves.
// Throughput: one byte per cycle while the input is not stalled by a full
// command queue; the front classifies a byte in the cycle it is taken and
// queues a command for the back. A start tag closed by '/' replays the stored
// tag name from the name memory a byte at a time (registered read, then send).
// Reset puts the lexer in the state before the first '<', empties the
// queue and drops any result not yet taken.
// When the receiver stalls, the output register holds, the back stops
// popping, and the input stalls once the command queue is full.
`default_nettype none
module xml_markup_tokenizer_top
  import xmt_pkg::*;
#(
  parameter int NAME_DEPTH = NAME_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] segment_kind,
  output logic       has_byte,
  output logic       segment_end,
  output logic       text_nonspace,
  output logic       parse_error,
  output logic       last
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_out;

  // classification front end
  xmt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // command queue
  xmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // result back end with name replay
  xmt_back #(
    .NAME_DEPTH (NAME_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .segment_kind  (segment_kind),
    .has_byte      (has_byte),
    .segment_end   (segment_end),
    .text_nonspace (text_nonspace),
    .parse_error   (parse_error),
    .last          (last)
  );

endmodule
`default_nettype wire

// ----- sv/xmt_queue.sv -----
`default_nettype none
module xmt_queue
  import xmt_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  push,
  input  cmd_t push_data,
  output logic full,
  input  wire  pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[head];

  // pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == QPTR_W'(QDEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == QPTR_W'(QDEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/xmt_front.sv -----
`default_nettype none
module xmt_front
  import xmt_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_byte,
  input  wire        q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  mode_t      mode, mode_next;
  logic       bracket_seen, bracket_seen_next;
  logic       in_quotes, in_quotes_next;
  logic       error_seen, error_seen_next;
  logic       text_ns, text_ns_next;
  logic [1:0] hold_cnt, hold_cnt_next;
  logic [7:0] hold0, hold0_next;
  logic [7:0] hold1, hold1_next;
  logic       emit;
  cmd_t       cmd;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && emit;
  assign q_data   = cmd;

  // classify one byte against the current mode
  always_comb begin
    mode_next         = mode;
    bracket_seen_next = bracket_seen;
    in_quotes_next    = in_quotes;
    error_seen_next   = error_seen;
    text_ns_next      = text_ns;
    hold_cnt_next     = hold_cnt;
    hold0_next        = hold0;
    hold1_next        = hold1;
    emit              = 1'b0;
    cmd               = '0;
    if (error_seen) begin
      emit    = 1'b1;
      cmd.err = 1'b1;
    end else begin
      unique case (mode)
        MODE_TEXT: begin
          emit = 1'b1;
          if (in_byte == CH_LT) begin
            cmd.kind          = KIND_TEXT;
            cmd.seg_end       = 1'b1;
            cmd.nonspace      = text_ns;
            mode_next         = MODE_BRACKET;
            bracket_seen_next = 1'b1;
          end else begin
            cmd.kind = KIND_TEXT;
            cmd.has  = 1'b1;
            cmd.data = in_byte;
            if (!is_ws(in_byte)) begin
              text_ns_next = 1'b1;
            end
          end
        end
        MODE_BRACKET: begin
          if (!bracket_seen) begin
            if (in_byte == CH_LT) begin
              bracket_seen_next = 1'b1;
            end
          end else begin
            bracket_seen_next = 1'b0;
            priority if (in_byte == CH_QMARK) begin
              mode_next = MODE_DECL;
            end else if (in_byte == CH_SLASH) begin
              mode_next = MODE_ETAG;
            end else if (in_byte == CH_BANG) begin
              mode_next = MODE_SIGN;
            end else if (is_name_char(in_byte)) begin
              mode_next      = MODE_STAG;
              in_quotes_next = 1'b0;
              emit           = 1'b1;
              cmd.kind       = KIND_STAG;
              cmd.has        = 1'b1;
              cmd.data       = in_byte;
              cmd.name_clear = 1'b1;
              cmd.name_feed  = 1'b1;
            end else begin
              bracket_seen_next = 1'b1;
              error_seen_next   = 1'b1;
              emit              = 1'b1;
              cmd.err           = 1'b1;
            end
          end
        end
        MODE_DECL, MODE_ETAG, MODE_DOCTYPE: begin
          emit = 1'b1;
          priority if (mode == MODE_DECL) begin
            cmd.kind = KIND_DECL;
          end else if (mode == MODE_ETAG) begin
            cmd.kind = KIND_ETAG;
          end else begin
            cmd.kind = KIND_DOCTYPE;
          end
          if (in_byte == CH_GT) begin
            cmd.seg_end  = 1'b1;
            mode_next    = MODE_TEXT;
            text_ns_next = 1'b0;
          end else begin
            cmd.has  = 1'b1;
            cmd.data = in_byte;
          end
        end
        MODE_STAG: begin
          emit     = 1'b1;
          cmd.kind = KIND_STAG;
          priority if (in_byte == CH_GT && !in_quotes) begin
            cmd.seg_end    = 1'b1;
            in_quotes_next = 1'b0;
            mode_next      = MODE_TEXT;
            text_ns_next   = 1'b0;
          end else if (in_byte == CH_SLASH && !in_quotes) begin
            cmd.seg_end    = 1'b1;
            cmd.replay     = 1'b1;
            in_quotes_next = 1'b0;
            mode_next      = MODE_ETAG;
          end else begin
            cmd.has       = 1'b1;
            cmd.data      = in_byte;
            cmd.name_feed = 1'b1;
            if (in_byte == CH_DQUOT || in_byte == CH_SQUOT) begin
              in_quotes_next = !in_quotes;
            end
          end
        end
        MODE_SIGN: begin
          priority if (in_byte == CH_LBRK) begin
            mode_next    = MODE_TEXT;
            text_ns_next = 1'b0;
          end else if (in_byte == CH_DASH) begin
            mode_next     = MODE_COMMENT;
            hold_cnt_next = 2'd0;
          end else if (is_upper(in_byte)) begin
            mode_next = MODE_DOCTYPE;
            emit      = 1'b1;
            cmd.kind  = KIND_DOCTYPE;
            cmd.has   = 1'b1;
            cmd.data  = in_byte;
          end else begin
            error_seen_next = 1'b1;
            emit            = 1'b1;
            cmd.err         = 1'b1;
          end
        end
        MODE_COMMENT: begin
          priority if (in_byte == CH_GT && hold_cnt == 2'd2 &&
                       hold0 == CH_DASH && hold1 == CH_DASH) begin
            emit          = 1'b1;
            cmd.kind      = KIND_COMMENT;
            cmd.seg_end   = 1'b1;
            hold_cnt_next = 2'd0;
            mode_next     = MODE_TEXT;
            text_ns_next  = 1'b0;
          end else if (hold_cnt != 2'd2) begin
            if (!hold_cnt[0]) begin
              hold0_next = in_byte;
            end else begin
              hold1_next = in_byte;
            end
            hold_cnt_next = hold_cnt + 1'b1;
          end else begin
            emit       = 1'b1;
            cmd.kind   = KIND_COMMENT;
            cmd.has    = 1'b1;
            cmd.data   = hold0;
            hold0_next = hold1;
            hold1_next = in_byte;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BRACKET;
      bracket_seen <= 1'b0;
      in_quotes    <= 1'b0;
      error_seen   <= 1'b0;
      text_ns      <= 1'b0;
      hold_cnt     <= 2'd0;
    end else if (accept) begin
      mode         <= mode_next;
      bracket_seen <= bracket_seen_next;
      in_quotes    <= in_quotes_next;
      error_seen   <= error_seen_next;
      text_ns      <= text_ns_next;
      hold_cnt     <= hold_cnt_next;
    end
  end

  // comment hold bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      hold0 <= hold0_next;
      hold1 <= hold1_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/xmt_back.sv -----
`default_nettype none
module xmt_back
  import xmt_pkg::*;
#(
  parameter int NAME_DEPTH = NAME_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        q_empty,
  input  cmd_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] segment_kind,
  output logic       has_byte,
  output logic       segment_end,
  output logic       text_nonspace,
  output logic       parse_error,
  output logic       last
);

  localparam int IDX_W = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
  localparam int LEN_W = $clog2(NAME_DEPTH + 1);

  bk_state_t        state;
  logic [7:0]       name_mem [NAME_DEPTH];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] name_len;
  logic             name_closed;
  logic [LEN_W-1:0] len_eff;
  logic             closed_eff;
  logic             out_free;
  logic             wr_en;
  logic             replay_go;
  logic             send_last;

  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == BK_CMD) && !q_empty && out_free;
  assign len_eff    = q_data.name_clear ? '0 : name_len;
  assign closed_eff = q_data.name_clear ? 1'b0 : name_closed;
  assign wr_en      = q_pop && q_data.name_feed && !closed_eff && !is_ws(q_data.data) &&
                      (len_eff < LEN_W'(NAME_DEPTH));
  assign replay_go  = q_data.replay && (name_len != '0);
  assign send_last  = ({{(LEN_W > IDX_W ? LEN_W - IDX_W : 0){1'b0}}, idx} ==
                       LEN_W'(name_len - 1'b1));

  // tag name store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      name_mem[len_eff[IDX_W-1:0]] <= q_data.data;
    end
    rd_data <= name_mem[idx];
  end

  // name length tracking and replay sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_CMD;
      idx         <= '0;
      name_len    <= '0;
      name_closed <= 1'b0;
    end else begin
      unique case (state)
        BK_CMD: begin
          if (q_pop) begin
            if (q_data.name_feed && !closed_eff && is_ws(q_data.data)) begin
              name_closed <= 1'b1;
            end else begin
              name_closed <= closed_eff;
            end
            name_len <= wr_en ? len_eff + 1'b1 : len_eff;
            if (replay_go) begin
              idx   <= '0;
              state <= BK_FETCH;
            end
          end
        end
        BK_FETCH: begin
          state <= BK_SEND;
        end
        BK_SEND: begin
          if (out_free) begin
            if (send_last) begin
              state <= BK_CMD;
            end else begin
              idx   <= idx + 1'b1;
              state <= BK_FETCH;
            end
          end
        end
        default: begin
          state <= BK_CMD;
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop || (state == BK_SEND && out_free)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte      <= q_data.has ? q_data.data : 8'd0;
      segment_kind  <= q_data.kind;
      has_byte      <= q_data.has;
      segment_end   <= q_data.seg_end;
      text_nonspace <= q_data.nonspace;
      parse_error   <= q_data.err;
      last          <= !replay_go;
    end else if (state == BK_SEND && out_free) begin
      out_byte      <= rd_data;
      segment_kind  <= KIND_ETAG;
      has_byte      <= 1'b1;
      segment_end   <= 1'b0;
      text_nonspace <= 1'b0;
      parse_error   <= 1'b0;
      last          <= send_last;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/xml_markup_tokenizer_top_test.sv -----
`timescale 1ns / 1ps

module xml_markup_tokenizer_top_test;
  import xmt_pkg::*;

  localparam int NAME_DEPTH = NAME_DEPTH_DEF;

  // one result item as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       has;
    logic       seg_end;
    logic       nonspace;
    logic       err;
    logic       is_last;
  } lex_result_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    FROM_MODEL,
    NO_RESULT,
    ONE_RESULT
  } how_t;

  typedef struct packed {
    logic [7:0]  b;
    how_t        how;
    lex_result_t want;
  } doc_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] segment_kind;
  logic       has_byte;
  logic       segment_end;
  logic       text_nonspace;
  logic       parse_error;
  logic       last;

  // lexer state kept by the testbench
  mode_t      lex_mode = MODE_BRACKET;
  logic       lt_seen = 1'b0;
  logic       quote_open = 1'b0;
  logic       error_latched = 1'b0;
  logic [7:0] name_mem [NAME_DEPTH];
  int         name_len = 0;
  logic       name_done = 1'b0;
  logic [7:0] hold [2];
  int         hold_cnt = 0;
  logic       text_ns = 1'b0;

  lex_result_t step_results[$];
  lex_result_t expected_results[$];
  doc_row_t    dir_rows[$];
  logic [7:0]  doc_q[$];

  int item_count = 0;
  int mismatch_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  xml_markup_tokenizer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .segment_kind (segment_kind),
    .has_byte     (has_byte),
    .segment_end  (segment_end),
    .text_nonspace(text_nonspace),
    .parse_error  (parse_error),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic ws_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic name_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == ":" || c == "-" || c == "." || c == "_";
  endfunction

  function automatic lex_result_t make_result(input logic [7:0] data, input logic [2:0] kind,
                                              input logic has, input logic seg_end,
                                              input logic ns, input logic err);
    lex_result_t r;
    r.data     = has ? data : 8'h00;
    r.kind     = kind;
    r.has      = has;
    r.seg_end  = seg_end;
    r.nonspace = ns;
    r.err      = err;
    r.is_last  = 1'b0;
    return r;
  endfunction

  task automatic enter_text();
    lex_mode = MODE_TEXT;
    text_ns  = 1'b0;
  endtask

  // start tag content byte: name capture and quote toggle
  task automatic stag_content(input logic [7:0] c);
    step_results.push_back(make_result(c, KIND_STAG, 1, 0, 0, 0));
    if (!name_done) begin
      if (ws_byte(c)) begin
        name_done = 1'b1;
      end else if (name_len < NAME_DEPTH) begin
        name_mem[name_len] = c;
        name_len++;
      end
    end
    if (c == CH_DQUOT || c == CH_SQUOT) quote_open = ~quote_open;
  endtask

  // expected results of one document byte, left in step_results
  task automatic lex_byte(input logic [7:0] c);
    logic [2:0]  seg_kind;
    lex_result_t r;
    step_results.delete();
    if (error_latched) begin
      step_results.push_back(make_result(8'h00, KIND_TEXT, 0, 0, 0, 1));
    end else begin
      case (lex_mode)
        MODE_TEXT: begin
          if (c == CH_LT) begin
            step_results.push_back(make_result(8'h00, KIND_TEXT, 0, 1, text_ns, 0));
            lex_mode = MODE_BRACKET;
            lt_seen  = 1'b1;
          end else begin
            step_results.push_back(make_result(c, KIND_TEXT, 1, 0, 0, 0));
            if (!ws_byte(c)) text_ns = 1'b1;
          end
        end
        MODE_BRACKET: begin
          if (!lt_seen) begin
            if (c == CH_LT) lt_seen = 1'b1;
          end else begin
            lt_seen = 1'b0;
            if (c == CH_QMARK) begin
              lex_mode = MODE_DECL;
            end else if (c == CH_SLASH) begin
              lex_mode = MODE_ETAG;
            end else if (c == CH_BANG) begin
              lex_mode = MODE_SIGN;
            end else if (name_byte(c)) begin
              lex_mode   = MODE_STAG;
              quote_open = 1'b0;
              name_len   = 0;
              name_done  = 1'b0;
              stag_content(c);
            end else begin
              lt_seen       = 1'b1;
              error_latched = 1'b1;
              step_results.push_back(make_result(8'h00, KIND_TEXT, 0, 0, 0, 1));
            end
          end
        end
        MODE_DECL, MODE_ETAG, MODE_DOCTYPE: begin
          seg_kind = (lex_mode == MODE_DECL) ? KIND_DECL :
                     (lex_mode == MODE_ETAG) ? KIND_ETAG : KIND_DOCTYPE;
          if (c == CH_GT) begin
            step_results.push_back(make_result(8'h00, seg_kind, 0, 1, 0, 0));
            enter_text();
          end else begin
            step_results.push_back(make_result(c, seg_kind, 1, 0, 0, 0));
          end
        end
        MODE_STAG: begin
          if (c == CH_GT && !quote_open) begin
            step_results.push_back(make_result(8'h00, KIND_STAG, 0, 1, 0, 0));
            quote_open = 1'b0;
            enter_text();
          end else if (c == CH_SLASH && !quote_open) begin
            // self-closing: end the start tag and replay the name as an end tag
            step_results.push_back(make_result(8'h00, KIND_STAG, 0, 1, 0, 0));
            for (int i = 0; i < name_len; i++)
              step_results.push_back(make_result(name_mem[i], KIND_ETAG, 1, 0, 0, 0));
            quote_open = 1'b0;
            lex_mode   = MODE_ETAG;
          end else begin
            stag_content(c);
          end
        end
        MODE_SIGN: begin
          if (c == CH_LBRK) begin
            enter_text();
          end else if (c == CH_DASH) begin
            lex_mode = MODE_COMMENT;
            hold_cnt = 0;
          end else if (c >= "A" && c <= "Z") begin
            lex_mode = MODE_DOCTYPE;
            step_results.push_back(make_result(c, KIND_DOCTYPE, 1, 0, 0, 0));
          end else begin
            error_latched = 1'b1;
            step_results.push_back(make_result(8'h00, KIND_TEXT, 0, 0, 0, 1));
          end
        end
        default: begin
          // comment bytes trail by two so the closing dashes never show
          if (c == CH_GT && hold_cnt >= 2 && hold[0] == CH_DASH && hold[1] == CH_DASH) begin
            step_results.push_back(make_result(8'h00, KIND_COMMENT, 0, 1, 0, 0));
            hold_cnt = 0;
            enter_text();
          end else if (hold_cnt < 2) begin
            hold[hold_cnt] = c;
            hold_cnt++;
          end else begin
            step_results.push_back(make_result(hold[0], KIND_COMMENT, 1, 0, 0, 0));
            hold[0] = hold[1];
            hold[1] = c;
          end
        end
      endcase
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.is_last = 1'b1;
      step_results.push_back(r);
    end
  endtask

  // one document byte through the input channel, expectation queued on accept
  task automatic send_item(input logic [7:0] b, input how_t how, input lex_result_t want);
    lex_result_t r;
    case ((item_count / 24) % 4)
      0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1:       begin tx_idle_pct = 56; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 56; end
      default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
    endcase
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do begin
      @(negedge clk);
    end while (in_stall);
    lex_byte(b);
    if (how == FROM_MODEL) begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end else if (how == ONE_RESULT) begin
      r = want;
      r.is_last = 1'b1;
      expected_results.push_back(r);
    end
    @(posedge clk);
    item_count++;
  endtask

  task automatic add_row(input logic [7:0] b, input how_t how, input lex_result_t want);
    doc_row_t row;
    row.b    = b;
    row.how  = how;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic [7:0] rand_content(input logic no_gt, input logic no_quote);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_LT || (no_gt && c == CH_GT) ||
               (no_quote && (c == CH_DQUOT || c == CH_SQUOT)));
    return c;
  endfunction

  function automatic logic [7:0] rand_ws();
    return ($urandom_range(4) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(4));
  endfunction

  task automatic push_name(input int n);
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789:-._";
    repeat (n) doc_q.push_back(pool[$urandom_range(pool.len() - 1)]);
  endtask

  // mostly well-formed markup with random content, some broken pieces
  task automatic gen_document(input int want_len);
    int         pick;
    logic [7:0] q;
    while (doc_q.size() < want_len) begin
      repeat ($urandom_range(4))
        doc_q.push_back(($urandom_range(3) == 0) ? rand_ws() : rand_content(0, 0));
      doc_q.push_back(CH_LT);
      pick = $urandom_range(99);
      if (pick < 40) begin
        // start tag, now and then with a long name that can exceed the replay depth
        push_name(($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6));
        repeat ($urandom_range(3)) begin
          doc_q.push_back(rand_ws());
          push_name($urandom_range(1, 4));
          doc_q.push_back("=");
          q = $urandom_range(1) ? CH_DQUOT : CH_SQUOT;
          doc_q.push_back(q);
          repeat ($urandom_range(5))
            doc_q.push_back(($urandom_range(3) == 0) ?
                            ($urandom_range(1) ? CH_GT : CH_SLASH) : rand_content(0, 1));
          if ($urandom_range(19) != 0)
            doc_q.push_back(($urandom_range(7) == 0) ? ((q == CH_DQUOT) ? CH_SQUOT : CH_DQUOT)
                                                     : q);
        end
        if ($urandom_range(3) == 0) begin
          doc_q.push_back(CH_SLASH);
          if ($urandom_range(1)) doc_q.push_back(rand_ws());
        end
        doc_q.push_back(CH_GT);
      end else if (pick < 55) begin
        doc_q.push_back(CH_SLASH);
        push_name($urandom_range(1, 6));
        doc_q.push_back(CH_GT);
      end else if (pick < 70) begin
        doc_q.push_back(CH_BANG);
        doc_q.push_back(CH_DASH);
        doc_q.push_back(CH_DASH);
        repeat ($urandom_range(6))
          doc_q.push_back(($urandom_range(3) == 0) ? CH_DASH : rand_content(0, 0));
        doc_q.push_back(CH_DASH);
        doc_q.push_back(CH_DASH);
        doc_q.push_back(CH_GT);
      end else if (pick < 80) begin
        doc_q.push_back(CH_QMARK);
        repeat ($urandom_range(5)) doc_q.push_back(rand_content(1, 0));
        doc_q.push_back(CH_GT);
      end else if (pick < 90) begin
        doc_q.push_back(CH_BANG);
        doc_q.push_back(8'($urandom_range("A", "Z")));
        repeat ($urandom_range(5)) doc_q.push_back(rand_content(1, 0));
        doc_q.push_back(CH_GT);
      end else if (pick < 95) begin
        doc_q.push_back(CH_BANG);
        doc_q.push_back(CH_LBRK);
      end else begin
        // declaration left open, later markup becomes its content
        doc_q.push_back(CH_QMARK);
        repeat ($urandom_range(4)) doc_q.push_back(rand_content(0, 0));
      end
    end
  endtask

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // result check, sampled before the accepting edge
  always @(negedge clk) begin : result_check
    lex_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected item: out_byte %h kind %0d end %b err %b", $time,
                 out_byte, segment_kind, segment_end, parse_error);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("segment_kind", want.kind, segment_kind);
        check_field("has_byte", want.has, has_byte);
        check_field("segment_end", want.seg_end, segment_end);
        check_field("text_nonspace", want.nonspace, text_nonspace);
        check_field("parse_error", want.err, parse_error);
        check_field("last", want.is_last, last);
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  b;
    lex_result_t err_res;
    err_res = make_result(8'h00, KIND_TEXT, 0, 0, 0, 1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    add_row(8'hFF, NO_RESULT, '0);
    add_row(CH_LT, NO_RESULT, '0);
    add_row(CH_QMARK, NO_RESULT, '0);
    add_row("x", ONE_RESULT, make_result("x", KIND_DECL, 1, 0, 0, 0));
    add_row(CH_GT, ONE_RESULT, make_result(8'h00, KIND_DECL, 0, 1, 0, 0));
    add_row(8'h09, ONE_RESULT, make_result(8'h09, KIND_TEXT, 1, 0, 0, 0));
    add_row(CH_LT, ONE_RESULT, make_result(8'h00, KIND_TEXT, 0, 1, 0, 0));
    add_row(CH_BANG, NO_RESULT, '0);
    add_row(CH_DASH, NO_RESULT, '0);
    add_row(CH_DASH, NO_RESULT, '0);
    add_row(CH_GT, NO_RESULT, '0);
    add_row(CH_DASH, ONE_RESULT, make_result(CH_DASH, KIND_COMMENT, 1, 0, 0, 0));
    add_row(CH_DASH, ONE_RESULT, make_result(CH_GT, KIND_COMMENT, 1, 0, 0, 0));
    add_row(CH_GT, ONE_RESULT, make_result(8'h00, KIND_COMMENT, 0, 1, 0, 0));
    add_row(8'h00, ONE_RESULT, make_result(8'h00, KIND_TEXT, 1, 0, 0, 0));
    add_row(CH_LT, ONE_RESULT, make_result(8'h00, KIND_TEXT, 0, 1, 1, 0));
    add_row(CH_BANG, NO_RESULT, '0);
    add_row("D", ONE_RESULT, make_result("D", KIND_DOCTYPE, 1, 0, 0, 0));
    add_row(CH_GT, ONE_RESULT, make_result(8'h00, KIND_DOCTYPE, 0, 1, 0, 0));
    add_row(CH_LT, ONE_RESULT, make_result(8'h00, KIND_TEXT, 0, 1, 0, 0));
    add_row("b", FROM_MODEL, '0);
    add_row(CH_SQUOT, FROM_MODEL, '0);
    add_row(CH_SLASH, FROM_MODEL, '0);
    add_row(CH_DQUOT, FROM_MODEL, '0);
    add_row(CH_SLASH, FROM_MODEL, '0);
    add_row(CH_GT, FROM_MODEL, '0);
    add_row(CH_LT, FROM_MODEL, '0);
    add_row(CH_BANG, NO_RESULT, '0);
    add_row(CH_LBRK, NO_RESULT, '0);
    foreach (dir_rows[i]) send_item(dir_rows[i].b, dir_rows[i].how, dir_rows[i].want);

    // random document
    gen_document(130);
    foreach (doc_q[i]) send_item(doc_q[i], FROM_MODEL, '0);

    // close whatever segment is open, then force the sticky error
    while (lex_mode != MODE_TEXT && lex_mode != MODE_BRACKET && lex_mode != MODE_SIGN) begin
      case (lex_mode)
        MODE_STAG:    b = quote_open ? CH_DQUOT : CH_GT;
        MODE_COMMENT: b = (hold_cnt >= 2 && hold[0] == CH_DASH && hold[1] == CH_DASH) ?
                          CH_GT : CH_DASH;
        default:      b = CH_GT;
      endcase
      send_item(b, FROM_MODEL, '0);
    end
    if (lex_mode == MODE_TEXT) send_item(CH_LT, FROM_MODEL, '0);
    if (lex_mode == MODE_BRACKET && $urandom_range(1)) send_item(CH_BANG, NO_RESULT, '0);
    if (lex_mode == MODE_SIGN) begin
      do begin
        b = 8'($urandom_range(255));
      end while (b == CH_LBRK || b == CH_DASH || (b >= "A" && b <= "Z"));
    end else begin
      do begin
        b = 8'($urandom_range(255));
      end while (b == CH_QMARK || b == CH_SLASH || b == CH_BANG || name_byte(b));
    end
    send_item(b, ONE_RESULT, err_res);
    repeat (4) send_item(8'($urandom_range(255)), ONE_RESULT, err_res);
    in_valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
